/* rtl/core/mlpq_pkg.sv */
// Shared types, codes and widths for the multi-level priority queue.
package mlpq_pkg;

	// Parameter defaults
	localparam int DEF_NUM_LEVELS  = 16;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_WIDTH    = 8;

	// Fixed field widths of the stream payloads
	localparam int LEVEL_W   = 4;
	localparam int ACTION_W  = 8;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 3;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DROP  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_APPLY,
		ST_REPLY
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the incoming transaction
		logic lookup;  // level search and full check
		logic apply;   // store access and pointer update
		logic reply;   // load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;  // output register can take a result
	} dp_stat_t;

endpackage

/* rtl/core/mlpq_ctrl.sv */
// Sequencer for the priority queue: accept, lookup, apply, reply.
module mlpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output mlpq_pkg::cmd_t      cmd,
	input  mlpq_pkg::dp_stat_t  stat
);
	import mlpq_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_LOOKUP;
				end
			end
			ST_LOOKUP: state_next = ST_APPLY;
			ST_APPLY:  state_next = ST_REPLY;
			ST_REPLY: begin
				if (stat.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_APPLY:  cmd.apply  = 1'b1;
			ST_REPLY:  cmd.reply  = stat.out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/mlpq_dp.sv */
// Datapath: entry store, per-level pointers and counts, level search, output register.
module mlpq_dp #(
	parameter int NUM_LEVELS  = mlpq_pkg::DEF_NUM_LEVELS,
	parameter int QUEUE_DEPTH = mlpq_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH    = mlpq_pkg::DEF_ID_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mlpq_pkg::cmd_t                    cmd,
	output mlpq_pkg::dp_stat_t                stat,
	input  logic [mlpq_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mlpq_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [mlpq_pkg::M_TUSER_W-1:0]    m_tuser
);
	import mlpq_pkg::*;

	localparam int LW    = $clog2(NUM_LEVELS);
	localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(DEPTH + 1);

	// Captured request
	logic                req_pop_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic [ID_WIDTH-1:0] id_q;

	// Per-level queue state
	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [PW-1:0] tail_q [NUM_LEVELS];
	logic [CW-1:0] cnt_q  [NUM_LEVELS];
	logic [TW-1:0] total_q;

	// Entry store
	logic [ID_WIDTH-1:0] mem [DEPTH];
	logic [ID_WIDTH-1:0] rd_data_q;

	// Lookup results
	logic [LW-1:0] sel_s1;
	logic          found_s1;
	logic          drop_s1;

	// Output register
	logic                m_tvalid_q;
	logic                o_valid_q;
	logic [ACTION_W-1:0] o_action_q;
	logic [LEVEL_W-1:0]  o_level_q;
	logic                o_more_q;
	status_t             o_status_q;

	logic [LW-1:0] push_idx;
	logic          in_range;
	logic [LW-1:0] enc_lvl;
	logic          enc_found;
	logic [LW-1:0] act_lvl;
	logic [PW-1:0] act_ptr;
	logic [AW-1:0] addr;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign push_idx = LW'(lvl_q);
	assign in_range = (9'(lvl_q) < 9'(NUM_LEVELS));

	// Lowest-numbered non-empty level
	always_comb begin
		enc_found = 1'b0;
		enc_lvl   = '0;
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			if (cnt_q[k] != '0) begin
				enc_found = 1'b1;
				enc_lvl   = LW'(k);
			end
		end
	end

	// Store address
	assign act_lvl = req_pop_q ? sel_s1 : push_idx;
	assign act_ptr = req_pop_q ? head_q[act_lvl] : tail_q[act_lvl];
	assign addr    = AW'(act_lvl) * AW'(QUEUE_DEPTH) + AW'(act_ptr);

	// Request capture and lookup
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_pop_q <= s_tuser;
			lvl_q     <= s_tdata[LEVEL_W-1:0];
			id_q      <= ID_WIDTH'(s_tdata[LEVEL_W +: ACTION_W]);
		end
		if (cmd.lookup) begin
			sel_s1   <= enc_lvl;
			found_s1 <= enc_found;
			drop_s1  <= !in_range || (cnt_q[push_idx] == CW'(QUEUE_DEPTH));
		end
	end

	// Entry store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.apply && !req_pop_q && !drop_s1) begin
			mem[addr] <= id_q;
		end
		if (cmd.apply && req_pop_q && found_s1) begin
			rd_data_q <= mem[addr];
		end
	end

	// Pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LEVELS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				cnt_q[k]  <= '0;
			end
			total_q <= '0;
		end else if (cmd.apply) begin
			if (!req_pop_q && !drop_s1) begin
				tail_q[act_lvl] <= next_ptr(tail_q[act_lvl]);
				cnt_q[act_lvl]  <= cnt_q[act_lvl] + CW'(1);
				total_q         <= total_q + TW'(1);
			end else if (req_pop_q && found_s1) begin
				head_q[act_lvl] <= next_ptr(head_q[act_lvl]);
				cnt_q[act_lvl]  <= cnt_q[act_lvl] - CW'(1);
				total_q         <= total_q - TW'(1);
			end
		end
	end

	// Output handshake
	assign stat.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.reply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			o_more_q <= (total_q != '0);
			if (req_pop_q && found_s1) begin
				o_valid_q  <= 1'b1;
				o_action_q <= ACTION_W'(rd_data_q);
				o_level_q  <= LEVEL_W'(sel_s1);
				o_status_q <= STAT_OK;
			end else begin
				o_valid_q  <= 1'b0;
				o_action_q <= '0;
				o_level_q  <= '0;
				if (req_pop_q) begin
					o_status_q <= STAT_EMPTY;
				end else if (drop_s1) begin
					o_status_q <= STAT_DROP;
				end else begin
					o_status_q <= STAT_OK;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, o_more_q, o_level_q, o_action_q};
	assign m_tuser  = {o_status_q, o_valid_q};

	// Occupancy never exceeds the store size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(DEPTH))
		else $error("total entry count above store size");

	// An accepted push always targets a level with room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && !req_pop_q && !drop_s1) |-> (cnt_q[push_idx] < CW'(QUEUE_DEPTH)))
		else $error("push written into a full level");

	// A successful pop removes exactly one entry from the selected level
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && req_pop_q && found_s1) |=>
		(cnt_q[sel_s1] == $past(cnt_q[sel_s1]) - CW'(1)))
		else $error("pop did not decrement level count");

	// An empty-pop result never reports pending entries or a delivered id
	a_empty_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (o_status_q == STAT_EMPTY)) |-> (!o_more_q && !o_valid_q))
		else $error("empty pop result carries data");

endmodule

/* rtl/core/multi_level_priority_queue.sv */
// A result shows on m_tvalid after its transaction passes the lookup, apply and
// reply states. A new transaction is taken only in the idle state, once the last
// reply is loaded; the reply waits while the output register is stalled.
// Reset: arst_n clears state, head/tail pointers and level counts; the entry store
// is left uninitialized and needs no clearing pass.
module multi_level_priority_queue #(
	parameter int NUM_LEVELS  = mlpq_pkg::DEF_NUM_LEVELS,
	parameter int QUEUE_DEPTH = mlpq_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH    = mlpq_pkg::DEF_ID_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mlpq_pkg::S_TDATA_W-1:0]    s_tdata,   // level[3:0], action_id[11:4]
	input  logic                              s_tuser,   // req_type[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mlpq_pkg::M_TDATA_W-1:0]    m_tdata,   // out_action[7:0], out_level[11:8],
	                                                     // more_pending[12]
	output logic [mlpq_pkg::M_TUSER_W-1:0]    m_tuser    // out_valid[0], status[2:1]
);
	import mlpq_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	mlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	mlpq_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
